@@ hdl/kts_pkg.sv @@
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants of the keyed tableau cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package kts_pkg;

  // Fixed widths of the item fields
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned ROW_W   = 7;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned STAT_W  = 3;
  // Length snapshot wide enough for the largest table (256 symbols)
  localparam int unsigned LEN_W   = 9;
  // Headroom for position + row / position + position before the wrap
  localparam int unsigned SUM_W   = 10;
  localparam int unsigned SYM_CNT = 256;

  typedef enum logic [FUNC_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_ENCRYPT = 2'd2,
    OP_DECRYPT = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_BAD_ROW = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  // What the back end has to do with a classified item
  typedef enum logic [1:0] {
    JOB_REPORT  = 2'd0,
    JOB_WRITE   = 2'd1,
    JOB_ENCRYPT = 2'd2,
    JOB_DECRYPT = 2'd3
  } job_kind_e;

  typedef struct packed {
    job_kind_e        kind;
    status_e          status;
    logic [SYM_W-1:0] sym_a;
    logic [SYM_W-1:0] sym_b;
    logic [ROW_W-1:0] row;
    logic [LEN_W-1:0] len;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE     = 3'd0,
    BK_POS_A    = 3'd1,
    BK_POS_B    = 3'd2,
    BK_SYM_TOP  = 3'd3,
    BK_SYM_LAST = 3'd4
  } back_state_e;

endpackage

`default_nettype wire

@@ hdl/kts_ram.sv @@
// ----------------------------------------------------------------------------
// kts_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  wire logic [WIDTH-1:0]                  wdata_i,
  input  wire logic                              re_i,
  input  wire logic [$clog2(DEPTH)-1:0]          raddr_i,
  output logic      [WIDTH-1:0]                  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/kts_front.sv @@
// ----------------------------------------------------------------------------
// kts_front
// Accepts items, keeps presence map and alphabet length, classifies items.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_front import kts_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [SYM_W-1:0]  in_first_i,
  input  wire logic [SYM_W-1:0]  in_second_i,
  input  wire logic [ROW_W-1:0]  row_pick_i,
  output job_t                   job_o
);

  localparam int unsigned LW = $clog2(MAX_SYMBOLS + 1);

  logic [SYM_CNT-1:0] present_q, present_d;
  logic [LW-1:0]      len_q, len_d;

  logic    has_a, has_b, is_empty, is_full, bad_row;
  op_e     op;

  always_comb begin
    op       = op_e'(func_i);
    has_a    = present_q[in_first_i];
    has_b    = present_q[in_second_i];
    is_empty = (len_q == '0);
    is_full  = (len_q == LW'(MAX_SYMBOLS));
    bad_row  = (LEN_W'(row_pick_i) >= LEN_W'(len_q));

    job_o.kind   = JOB_REPORT;
    job_o.status = ST_OK;
    job_o.sym_a  = in_first_i;
    job_o.sym_b  = in_second_i;
    job_o.row    = row_pick_i;
    job_o.len    = LEN_W'(len_q);

    present_d = present_q;
    len_d     = len_q;

    case (op)
      OP_CLEAR: begin
        present_d = '0;
        len_d     = '0;
      end
      OP_APPEND: begin
        if (!has_a) begin
          if (is_full) begin
            job_o.status = ST_FULL;
          end else begin
            job_o.kind           = JOB_WRITE;
            present_d[in_first_i] = 1'b1;
            len_d                = len_q + LW'(1);
          end
        end
      end
      OP_ENCRYPT: begin
        if (is_empty)      job_o.status = ST_EMPTY;
        else if (!has_a)   job_o.status = ST_UNKNOWN;
        else if (bad_row)  job_o.status = ST_BAD_ROW;
        else               job_o.kind   = JOB_ENCRYPT;
      end
      OP_DECRYPT: begin
        if (is_empty)              job_o.status = ST_EMPTY;
        else if (!has_a || !has_b) job_o.status = ST_UNKNOWN;
        else                       job_o.kind   = JOB_DECRYPT;
      end
      default: begin
        job_o.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      len_q     <= '0;
    end else if (accept_i) begin
      present_q <= present_d;
      len_q     <= len_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/kts_queue.sv @@
// ----------------------------------------------------------------------------
// kts_queue
// Two-entry job queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_queue import kts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      push_job_i,
  input  wire logic pop_i,
  output job_t      head_o,
  output logic      empty_o,
  output logic      full_o
);

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  logic do_push, do_pop;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/kts_back.sv @@
// ----------------------------------------------------------------------------
// kts_back
// Executes queued jobs against the alphabet and position memories.
// ----------------------------------------------------------------------------
`default_nettype none

module kts_back import kts_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 128
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  job_t                  head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  output logic                  finish_o,
  output logic                  done_o,
  output logic [SYM_W-1:0]      out_first_o,
  output logic [SYM_W-1:0]      out_second_o,
  output logic [STAT_W-1:0]     status_o
);

  localparam int unsigned PW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  back_state_e state_q, state_d;
  job_t        job_q, job_d;
  logic [PW-1:0]    p1_q, p1_d;
  logic [PW-1:0]    idx2_q, idx2_d;
  logic [SYM_W-1:0] o1_q, o1_d;

  logic             done_q;
  logic [SYM_W-1:0] res_first_q, res_first_d;
  logic [SYM_W-1:0] res_second_q, res_second_d;
  status_e          res_status_q, res_status_d;

  // memory ports
  logic             sym_we, sym_re, pos_we, pos_re;
  logic [PW-1:0]    sym_waddr, sym_raddr;
  logic [SYM_W-1:0] sym_rdata;
  logic [SYM_W-1:0] pos_raddr;
  logic [PW-1:0]    pos_rdata;

  // modular add, operands already below len
  logic [SUM_W-1:0] wrap_a, wrap_b, wrap_sum, wrap_res, len_ext, row_ext, top;

  kts_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (sym_we),
    .waddr_i (sym_waddr),
    .wdata_i (head_i.sym_a),
    .re_i    (sym_re),
    .raddr_i (sym_raddr),
    .rdata_o (sym_rdata)
  );

  kts_ram #(
    .WIDTH (PW),
    .DEPTH (SYM_CNT)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (head_i.sym_a),
    .wdata_i (sym_waddr),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  always_comb begin
    len_ext  = SUM_W'(job_q.len);
    row_ext  = SUM_W'(job_q.row);
    wrap_a   = (state_q == BK_POS_B) ? SUM_W'(p1_q) : SUM_W'(pos_rdata);
    wrap_b   = (state_q == BK_POS_B) ? SUM_W'(pos_rdata) : row_ext;
    wrap_sum = wrap_a + wrap_b;
    wrap_res = (wrap_sum >= len_ext) ? (wrap_sum - len_ext) : wrap_sum;
    top      = (row_ext == '0) ? '0 : (len_ext - row_ext);
  end

  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    p1_d         = p1_q;
    idx2_d       = idx2_q;
    o1_d         = o1_q;
    pop_o        = 1'b0;
    finish_o     = 1'b0;
    res_first_d  = '0;
    res_second_d = '0;
    res_status_d = ST_OK;
    sym_we       = 1'b0;
    sym_waddr    = head_i.len[PW-1:0];
    sym_re       = 1'b0;
    sym_raddr    = '0;
    pos_we       = 1'b0;
    pos_re       = 1'b0;
    pos_raddr    = head_i.sym_a;

    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          job_d = head_i;
          case (head_i.kind)
            JOB_REPORT: begin
              finish_o     = 1'b1;
              res_status_d = head_i.status;
            end
            JOB_WRITE: begin
              sym_we   = 1'b1;
              pos_we   = 1'b1;
              finish_o = 1'b1;
            end
            JOB_ENCRYPT, JOB_DECRYPT: begin
              pos_re  = 1'b1;
              state_d = BK_POS_A;
            end
            default: begin
              finish_o = 1'b1;
            end
          endcase
        end
      end
      BK_POS_A: begin
        if (job_q.kind == JOB_ENCRYPT) begin
          // first symbol is row top, second is shifted plaintext position
          idx2_d    = wrap_res[PW-1:0];
          sym_re    = 1'b1;
          sym_raddr = top[PW-1:0];
          state_d   = BK_SYM_TOP;
        end else begin
          p1_d      = pos_rdata;
          pos_re    = 1'b1;
          pos_raddr = job_q.sym_b;
          state_d   = BK_POS_B;
        end
      end
      BK_POS_B: begin
        sym_re    = 1'b1;
        sym_raddr = wrap_res[PW-1:0];
        state_d   = BK_SYM_LAST;
      end
      BK_SYM_TOP: begin
        o1_d      = sym_rdata;
        sym_re    = 1'b1;
        sym_raddr = idx2_q;
        state_d   = BK_SYM_LAST;
      end
      BK_SYM_LAST: begin
        finish_o = 1'b1;
        if (job_q.kind == JOB_ENCRYPT) begin
          res_first_d  = o1_q;
          res_second_d = sym_rdata;
        end else begin
          res_first_d  = sym_rdata;
        end
        state_d = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= finish_o;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    p1_q   <= p1_d;
    idx2_q <= idx2_d;
    o1_q   <= o1_d;
    if (finish_o) begin
      res_first_q  <= res_first_d;
      res_second_q <= res_second_d;
      res_status_q <= res_status_d;
    end
  end

  assign done_o       = done_q;
  assign out_first_o  = res_first_q;
  assign out_second_o = res_second_q;
  assign status_o     = res_status_q;

endmodule

`default_nettype wire

@@ hdl/keyed_tableau_cipher_top.sv @@
// ----------------------------------------------------------------------------
// keyed_tableau_cipher_top
// Keyed tableau cipher: alphabet build, encrypt and decrypt of symbols.
// ----------------------------------------------------------------------------
// One item is taken at a time: busy rises on accept and falls when the
// result is registered. Clear, append and every error case pass through
// the queue handoff and then register the result. Encrypt and decrypt
// take longer, set by three dependent reads of registered memories.
// Encrypt does a position lookup, then two alphabet reads through
// one port. Decrypt does two position lookups, then one alphabet read. Each
// result shows on done_o for exactly one cycle and cannot be held off; the
// receiver must take it then.
`default_nettype none

module keyed_tableau_cipher_top import kts_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire logic [SYM_W-1:0]  in_first_i,
  input  wire logic [SYM_W-1:0]  in_second_i,
  input  wire logic [ROW_W-1:0]  row_pick_i,
  output logic                   done_o,
  output logic [SYM_W-1:0]       out_first_o,
  output logic [SYM_W-1:0]       out_second_o,
  output logic [STAT_W-1:0]      status_o
);

  logic in_flight_q;
  logic accept, pop, finish, q_empty, q_full;
  job_t new_job, head_job;

  assign busy   = in_flight_q;
  assign accept = start && !in_flight_q && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_flight_q <= 1'b0;
    end else if (accept) begin
      in_flight_q <= 1'b1;
    end else if (finish) begin
      in_flight_q <= 1'b0;
    end
  end

  kts_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .in_first_i  (in_first_i),
    .in_second_i (in_second_i),
    .row_pick_i  (row_pick_i),
    .job_o       (new_job)
  );

  kts_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_job_i (new_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  kts_back #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .finish_o     (finish),
    .done_o       (done_o),
    .out_first_o  (out_first_o),
    .out_second_o (out_second_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire
